FILE: rtl/core/bdlp_pkg.sv
// bdlp_pkg: shared types, codes and constants of the button debounce block
// used by the channel interfaces, the per-key cell and the top level
// no dependencies
package bdlp_pkg;

	// fixed field widths
	localparam int OP_W      = 2;
	localparam int RAW_W     = 4;
	localparam int BTN_W     = 2;
	localparam int CNT_W     = 16;
	localparam int REG_IDX_W = 2;
	localparam int CFG_W     = 16;

	// default bank size
	localparam int NUM_KEYS_DEF = 4;

	// register reset values
	localparam logic [CNT_W-1:0] LONG_TICKS_RST  = 16'd200;
	localparam logic [CNT_W-1:0] REPEAT_TICKS_RST = 16'd100;
	localparam logic             PRESSED_LVL_RST = 1'b0;

	// raw level stored as released after reset
	localparam logic RELEASED_RST = ~PRESSED_LVL_RST;

	// item opcodes
	typedef enum logic [OP_W-1:0] {
		OP_TICK  = 2'd0,
		OP_PRESS = 2'd1,
		OP_LONG  = 2'd2
	} op_t;

	// configuration register indexes
	typedef enum logic [REG_IDX_W-1:0] {
		REG_LONG_TICKS   = 2'd0,
		REG_REPEAT_TICKS = 2'd1,
		REG_PRESSED_LVL  = 2'd2
	} reg_idx_t;

	// configuration seen by every key
	typedef struct packed {
		logic [CNT_W-1:0] long_press_ticks;
		logic [CNT_W-1:0] repeat_ticks;
		logic             pressed_level;
	} cfg_t;

	// per-key control for one word
	typedef struct packed {
		logic tick;
		logic level;
		logic clr_press;
		logic clr_long;
	} key_ctrl_t;

	// per-key sticky flags
	typedef struct packed {
		logic press_pend;
		logic long_pend;
	} key_flags_t;

endpackage

FILE: rtl/core/bdlp_if.sv
// bdlp_in_if / bdlp_out_if: valid-ready channels of the debounce block
// depends on bdlp_pkg
interface bdlp_in_if import bdlp_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [OP_W-1:0]  op;
	logic [RAW_W-1:0] raw_levels;
	logic [BTN_W-1:0] button;

	modport source (output valid, output op, output raw_levels, output button, input ready);
	modport sink   (input valid, input op, input raw_levels, input button, output ready);
endinterface

interface bdlp_out_if ();
	logic valid;
	logic ready;
	logic flag_was_set;

	modport source (output valid, output flag_was_set, input ready);
	modport sink   (input valid, input flag_was_set, output ready);
endinterface

FILE: rtl/core/bdlp_key.sv
// bdlp_key: one button: sample history, stable level, hold counter and flags
// depends on bdlp_pkg
module bdlp_key import bdlp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  key_ctrl_t  ctrl,
	output key_flags_t flags
);

	logic             older_q, middle_q, newest_q, stable_q;
	logic [CNT_W-1:0] cnt_q;
	logic             rep_q, press_q, long_q;

	logic             stable_n, rep_n, press_n, long_n;
	logic [CNT_W-1:0] cnt_n, cnt_dec;
	logic             agree, is_pressed;

	// three samples agree once the new one is shifted in
	assign agree      = (middle_q == newest_q) && (newest_q == ctrl.level);
	assign is_pressed = (ctrl.level == cfg.pressed_level);
	assign cnt_dec    = (cnt_q != '0) ? cnt_q - 1'b1 : '0;

	// next state of the key
	always_comb begin
		stable_n = stable_q;
		cnt_n    = cnt_q;
		rep_n    = rep_q;
		press_n  = press_q;
		long_n   = long_q;
		if (ctrl.tick && agree) begin
			if (stable_q != ctrl.level) begin
				stable_n = ctrl.level;
				if (is_pressed) begin
					press_n = 1'b1;
					if (!rep_q)
						cnt_n = cfg.long_press_ticks;
				end else begin
					rep_n = 1'b0;
				end
			end else if (cnt_dec == '0 && is_pressed) begin
				// hold expired: long event, force release, reload repeat
				stable_n = ~cfg.pressed_level;
				long_n   = 1'b1;
				cnt_n    = cfg.repeat_ticks;
				rep_n    = 1'b1;
			end else begin
				cnt_n = cnt_dec;
			end
		end
		if (ctrl.clr_press)
			press_n = 1'b0;
		if (ctrl.clr_long)
			long_n = 1'b0;
	end

	// key state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			older_q  <= RELEASED_RST;
			middle_q <= RELEASED_RST;
			newest_q <= RELEASED_RST;
			stable_q <= RELEASED_RST;
			cnt_q    <= '0;
			rep_q    <= 1'b0;
			press_q  <= 1'b0;
			long_q   <= 1'b0;
		end else begin
			if (ctrl.tick) begin
				older_q  <= middle_q;
				middle_q <= newest_q;
				newest_q <= ctrl.level;
			end
			stable_q <= stable_n;
			cnt_q    <= cnt_n;
			rep_q    <= rep_n;
			press_q  <= press_n;
			long_q   <= long_n;
		end
	end

	assign flags.press_pend = press_q;
	assign flags.long_pend  = long_q;

endmodule

FILE: rtl/core/button_debounce_long_press.sv
// button_debounce_long_press: debounced button bank with long press and repeat
// depends on bdlp_pkg, bdlp_if, bdlp_key
//
//   channel  | dir | payload                      | result
//   items    | in  | op, raw_levels, button       | tick: none, poll: one word
//   results  | out | flag_was_set                 | -
//   cfg      | in  | cfg_we, cfg_index, cfg_wdata | write only
//
// one word per cycle while no poll waits; a word is registered, then applied to every
// key cell in one pass, and a poll's flag is then caught in the result register
// a tick never waits; a poll waits in the input register only while the
// result register holds a word not yet taken
// arst_n clears all keys to released, counters and flags to zero, registers
// to their defaults; no clearing pass
module button_debounce_long_press import bdlp_pkg::*; #(
	parameter int NUM_KEYS = NUM_KEYS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	bdlp_in_if.sink              items,
	bdlp_out_if.source           results
);

	cfg_t             cfg_q;
	logic             valid_s1;
	logic [OP_W-1:0]  op_s1;
	logic [RAW_W-1:0] raw_s1;
	logic [BTN_W-1:0] btn_s1;
	logic             out_valid_q, flag_q;

	logic                is_poll, advance, fire, flag_sel;
	logic [NUM_KEYS-1:0] hit;
	key_flags_t          key_flags [NUM_KEYS];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.long_press_ticks <= LONG_TICKS_RST;
			cfg_q.repeat_ticks     <= REPEAT_TICKS_RST;
			cfg_q.pressed_level    <= PRESSED_LVL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LONG_TICKS:   cfg_q.long_press_ticks <= cfg_wdata[CNT_W-1:0];
				REG_REPEAT_TICKS: cfg_q.repeat_ticks     <= cfg_wdata[CNT_W-1:0];
				REG_PRESSED_LVL:  cfg_q.pressed_level    <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// stage 1 moves on unless a poll finds the result register blocked
	assign is_poll     = (op_s1 == OP_PRESS) || (op_s1 == OP_LONG);
	assign advance     = !is_poll || !out_valid_q || results.ready;
	assign fire        = valid_s1 && advance;
	assign items.ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (items.ready) begin
			valid_s1 <= items.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (items.ready && items.valid) begin
			op_s1  <= items.op;
			raw_s1 <= items.raw_levels;
			btn_s1 <= items.button;
		end
	end

	// key cells
	for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
		key_ctrl_t ctrl;
		logic      lvl;

		if (k < RAW_W) begin : g_pin
			assign lvl = raw_s1[k];
		end else begin : g_nopin
			assign lvl = 1'b0;
		end

		assign hit[k]         = (32'(btn_s1) == k);
		assign ctrl.tick      = fire && (op_s1 == OP_TICK);
		assign ctrl.level     = lvl;
		assign ctrl.clr_press = fire && (op_s1 == OP_PRESS) && hit[k];
		assign ctrl.clr_long  = fire && (op_s1 == OP_LONG) && hit[k];

		bdlp_key u_key (
			.clk    (clk),
			.arst_n (arst_n),
			.cfg    (cfg_q),
			.ctrl   (ctrl),
			.flags  (key_flags[k])
		);
	end

	// pick the polled flag; a button beyond the bank reads zero
	always_comb begin
		flag_sel = 1'b0;
		for (int k = 0; k < NUM_KEYS; k++) begin
			if (hit[k])
				flag_sel = (op_s1 == OP_PRESS) ? key_flags[k].press_pend
				                                : key_flags[k].long_pend;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && is_poll) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && is_poll)
			flag_q <= flag_sel;
	end

	assign results.valid        = out_valid_q;
	assign results.flag_was_set = flag_q;

endmodule

FILE: rtl/core/bdlp_checker.sv
// bdlp_checker: port-level checks of the debounce block, bound to the top level
// depends on button_debounce_long_press
module bdlp_checker (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic flag_was_set
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(flag_was_set))
		else $error("result word changed while stalled");

	// with the result register empty the input side never stalls
	a_in_free: assert property (@(posedge clk)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result register");

	// a taken result frees the input side in the same cycle
	a_in_follow: assert property (@(posedge clk)
		out_ready |-> in_ready)
		else $error("input stalled while results drain");

endmodule

bind button_debounce_long_press bdlp_checker u_bdlp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (items.ready),
	.out_valid    (results.valid),
	.out_ready    (results.ready),
	.flag_was_set (results.flag_was_set)
);
